// ----- rtl/lsc_pkg.sv -----
// line segment clipper package: region code layout, register indexes,
// controller/datapath command and status structs
// no dependencies
package lsc_pkg;

    typedef logic [3:0] region_t;

    localparam int RC_LEFT_BIT   = 0;
    localparam int RC_RIGHT_BIT  = 1;
    localparam int RC_BOTTOM_BIT = 2;
    localparam int RC_TOP_BIT    = 3;

    localparam int MAX_CLIPS      = 8;
    localparam int CLIP_CNT_WIDTH = $clog2(MAX_CLIPS + 1);

    localparam int CFG_INDEX_WIDTH = 8;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_WIN_LEFT   = cfg_index_t'(0);
    localparam cfg_index_t REG_WIN_BOTTOM = cfg_index_t'(1);
    localparam cfg_index_t REG_WIN_RIGHT  = cfg_index_t'(2);
    localparam cfg_index_t REG_WIN_TOP    = cfg_index_t'(3);

    localparam int WIN_LEFT_RESET   = 100;
    localparam int WIN_BOTTOM_RESET = 100;
    localparam int WIN_RIGHT_RESET  = 300;
    localparam int WIN_TOP_RESET    = 300;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic mult;
        logic div_start;
        logic update;
        logic emit;
        logic emit_acc;
    } lsc_cmd_t;

    typedef struct packed {
        logic both_zero;
        logic share;
        logic div_done;
    } lsc_sts_t;

endpackage

// ----- rtl/lsc_if.sv -----
// valid/ready channel interfaces: segment input, clip result, config write
// depends on lsc_pkg
interface lsc_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_out_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic signed [COORD_WIDTH-1:0] clip_start_x;
    logic signed [COORD_WIDTH-1:0] clip_start_y;
    logic signed [COORD_WIDTH-1:0] clip_end_x;
    logic signed [COORD_WIDTH-1:0] clip_end_y;

    modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                    clip_end_y, input ready);
    modport sink (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

interface lsc_cfg_if import lsc_pkg::*; #(parameter int COORD_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    cfg_index_t             index;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/line_segment_clipper_top.sv -----
// line segment clipper top level: window registers, output register,
// controller and datapath; depends on lsc_pkg, lsc_if, lsc_ctrl, lsc_dp
//
// seg_in carries one segment per transaction (two signed endpoints); seg_out
// carries one result per segment: accepted flag and clipped endpoints, all
// zero when the segment is rejected. cfg writes the window bounds: index 0
// left, 1 bottom, 2 right, 3 top; other indexes are ignored. cfg is always
// ready. cfg must be written only while the clipper is idle; the block
// itself does not enforce this. a trivially accepted or rejected segment
// goes from decide straight to finish; each edge move (at most 8) steps
// through setup, multiply, divide and update, and the serial divider
// yields one quotient bit per cycle.
// seg_in is ready only between segments. the result sits in an output
// register, so a new segment is taken while seg_out is stalled; a finished
// result waits in the controller until that register frees up.
// reset loads the window 100..300 on both axes and empties the output.
module line_segment_clipper_top import lsc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lsc_in_if.sink    seg_in,
    lsc_out_if.source seg_out,
    lsc_cfg_if.sink   cfg
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    logic                out_valid_reg;
    logic                out_acc_reg;
    logic signed [W-1:0] out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    lsc_cmd_t            cmd;
    lsc_sts_t            sts;
    logic                out_free;
    logic signed [W-1:0] x1, y1, x2, y2;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= W'(WIN_LEFT_RESET);
            win_bottom_reg <= W'(WIN_BOTTOM_RESET);
            win_right_reg  <= W'(WIN_RIGHT_RESET);
            win_top_reg    <= W'(WIN_TOP_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIN_LEFT:   win_left_reg   <= $signed(cfg.data);
                REG_WIN_BOTTOM: win_bottom_reg <= $signed(cfg.data);
                REG_WIN_RIGHT:  win_right_reg  <= $signed(cfg.data);
                REG_WIN_TOP:    win_top_reg    <= $signed(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || seg_out.ready;

    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seg_in.valid),
        .in_ready (seg_in.ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsc_dp #(
        .COORD_WIDTH (W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .win_left   (win_left_reg),
        .win_bottom (win_bottom_reg),
        .win_right  (win_right_reg),
        .win_top    (win_top_reg),
        .start_x    (seg_in.start_x),
        .start_y    (seg_in.start_y),
        .end_x      (seg_in.end_x),
        .end_y      (seg_in.end_y),
        .x1         (x1),
        .y1         (y1),
        .x2         (x2),
        .y2         (y2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (seg_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_acc_reg <= cmd.emit_acc;
            out_sx_reg  <= cmd.emit_acc ? x1 : '0;
            out_sy_reg  <= cmd.emit_acc ? y1 : '0;
            out_ex_reg  <= cmd.emit_acc ? x2 : '0;
            out_ey_reg  <= cmd.emit_acc ? y2 : '0;
        end
    end

    assign seg_out.valid        = out_valid_reg;
    assign seg_out.accepted     = out_acc_reg;
    assign seg_out.clip_start_x = out_sx_reg;
    assign seg_out.clip_start_y = out_sy_reg;
    assign seg_out.clip_end_x   = out_ex_reg;
    assign seg_out.clip_end_y   = out_ey_reg;

endmodule

// ----- rtl/lsc_div.sv -----
// serial restoring divider, one dividend bit per cycle, low quotient bits kept
// no dependencies
module lsc_div #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2*COORD_WIDTH-1:0]   dividend,
    input  logic [COORD_WIDTH-1:0]     divisor,
    output logic                       done,
    output logic [COORD_WIDTH-1:0]     quotient
);

    localparam int W     = COORD_WIDTH;
    localparam int CNT_W = $clog2(2 * W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [2*W-1:0]   dvd_reg;
    logic [W-1:0]     dvs_reg;
    logic [W-1:0]     quo_reg;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {rem_reg, dvd_reg[2*W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(2 * W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            dvd_reg <= {dvd_reg[2*W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/lsc_dp.sv -----
// clipper datapath: endpoint registers, region codes, edge operands,
// multiplier and serial divider; depends on lsc_pkg and lsc_div
module lsc_dp import lsc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsc_cmd_t                      cmd,
    output lsc_sts_t                      sts,
    input  logic signed [COORD_WIDTH-1:0] win_left,
    input  logic signed [COORD_WIDTH-1:0] win_bottom,
    input  logic signed [COORD_WIDTH-1:0] win_right,
    input  logic signed [COORD_WIDTH-1:0] win_top,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic signed [COORD_WIDTH-1:0] x1,
    output logic signed [COORD_WIDTH-1:0] y1,
    output logic signed [COORD_WIDTH-1:0] x2,
    output logic signed [COORD_WIDTH-1:0] y2
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;

    logic signed [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;

    region_t c1, c2, co;
    logic    side1, y_edge;

    logic signed [W-1:0]  edge_val, base_val;
    logic signed [DW-1:0] diff_x, diff_y, diff_ex, diff_ey;
    logic signed [DW-1:0] num_a, num_b, den;
    logic [DW-1:0]        abs_a, abs_b, abs_c;

    logic [W-1:0]        mag_a_reg, mag_b_reg, mag_c_reg;
    logic                neg_reg, y_edge_reg, side1_reg, den_zero_reg;
    logic signed [W-1:0] base_reg, edge_reg;
    logic [2*W-1:0]      prod_reg;

    logic         div_done;
    logic [W-1:0] quotient;
    logic [W-1:0] q_val;
    logic [W-1:0] new_coord;

    always_comb
    begin
        c1 = '0;
        c2 = '0;
        c1[RC_LEFT_BIT]   = x1_reg < win_left;
        c1[RC_RIGHT_BIT]  = !(x1_reg < win_left) && (x1_reg > win_right);
        c1[RC_BOTTOM_BIT] = y1_reg < win_bottom;
        c1[RC_TOP_BIT]    = !(y1_reg < win_bottom) && (y1_reg > win_top);
        c2[RC_LEFT_BIT]   = x2_reg < win_left;
        c2[RC_RIGHT_BIT]  = !(x2_reg < win_left) && (x2_reg > win_right);
        c2[RC_BOTTOM_BIT] = y2_reg < win_bottom;
        c2[RC_TOP_BIT]    = !(y2_reg < win_bottom) && (y2_reg > win_top);
    end

    always_comb
    begin
        side1  = c1 != '0;
        co     = side1 ? c1 : c2;
        y_edge = co[RC_TOP_BIT] | co[RC_BOTTOM_BIT];

        if (co[RC_TOP_BIT])
            edge_val = win_top;
        else if (co[RC_BOTTOM_BIT])
            edge_val = win_bottom;
        else if (co[RC_RIGHT_BIT])
            edge_val = win_right;
        else
            edge_val = win_left;

        diff_x  = DW'(x2_reg) - DW'(x1_reg);
        diff_y  = DW'(y2_reg) - DW'(y1_reg);
        diff_ex = DW'(edge_val) - DW'(x1_reg);
        diff_ey = DW'(edge_val) - DW'(y1_reg);

        num_a    = y_edge ? diff_x  : diff_y;
        num_b    = y_edge ? diff_ey : diff_ex;
        den      = y_edge ? diff_y  : diff_x;
        base_val = y_edge ? x1_reg  : y1_reg;

        abs_a = num_a[W] ? -num_a : num_a;
        abs_b = num_b[W] ? -num_b : num_b;
        abs_c = den[W]   ? -den   : den;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            mag_a_reg    <= abs_a[W-1:0];
            mag_b_reg    <= abs_b[W-1:0];
            mag_c_reg    <= abs_c[W-1:0];
            neg_reg      <= num_a[W] ^ num_b[W] ^ den[W];
            den_zero_reg <= den == '0;
            base_reg     <= base_val;
            edge_reg     <= edge_val;
            y_edge_reg   <= y_edge;
            side1_reg    <= side1;
        end
        if (cmd.mult)
        begin
            prod_reg <= {{W{1'b0}}, mag_a_reg} * {{W{1'b0}}, mag_b_reg};
        end
    end

    lsc_div #(
        .COORD_WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (mag_c_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (den_zero_reg)
            q_val = '0;
        else if (neg_reg)
            q_val = -quotient;
        else
            q_val = quotient;
        new_coord = base_reg + q_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x1_reg <= start_x;
            y1_reg <= start_y;
            x2_reg <= end_x;
            y2_reg <= end_y;
        end
        else if (cmd.update)
        begin
            if (side1_reg)
            begin
                x1_reg <= y_edge_reg ? $signed(new_coord) : edge_reg;
                y1_reg <= y_edge_reg ? edge_reg : $signed(new_coord);
            end
            else
            begin
                x2_reg <= y_edge_reg ? $signed(new_coord) : edge_reg;
                y2_reg <= y_edge_reg ? edge_reg : $signed(new_coord);
            end
        end
    end

    assign sts.both_zero = (c1 == '0) && (c2 == '0);
    assign sts.share     = (c1 & c2) != '0;
    assign sts.div_done  = div_done;

    assign x1 = x1_reg;
    assign y1 = y1_reg;
    assign x2 = x2_reg;
    assign y2 = y2_reg;

endmodule

// ----- rtl/lsc_ctrl.sv -----
// clipper controller: sequences decide, setup, multiply, divide and update
// steps per edge move; depends on lsc_pkg
module lsc_ctrl import lsc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    input  lsc_sts_t sts,
    output lsc_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DECIDE    = 8'b0000_0010,
        ST_SETUP     = 8'b0000_0100,
        ST_MULT      = 8'b0000_1000,
        ST_DIV_START = 8'b0001_0000,
        ST_DIV_WAIT  = 8'b0010_0000,
        ST_UPDATE    = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CLIP_CNT_WIDTH-1:0] clip_cnt_reg, clip_cnt_next;
    logic                      acc_reg, acc_next;

    always_comb
    begin
        state_next    = state_reg;
        clip_cnt_next = clip_cnt_reg;
        acc_next      = acc_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    clip_cnt_next = '0;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.both_zero)
                begin
                    acc_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (sts.share || clip_cnt_reg == CLIP_CNT_WIDTH'(MAX_CLIPS))
                begin
                    acc_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                clip_cnt_next = clip_cnt_reg + 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.emit_acc = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clip_cnt_reg <= '0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clip_cnt_reg <= clip_cnt_next;
            acc_reg      <= acc_next;
        end
    end

    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clip_cnt_reg <= CLIP_CNT_WIDTH'(MAX_CLIPS))
        else $error("edge move count above limit");

    a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider done right after start");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result emitted into busy output register");

    a_update_recheck: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> state_reg == ST_DECIDE)
        else $error("endpoint update not followed by code check");

endmodule
